[design/rpe2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpe2d_pkg
// Shared types and fixed constants of the 2D rotary position embedding block.
// ----------------------------------------------------------------------------
package rpe2d_pkg;

    // data word and working widths
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int ANG_W   = 38;          // col*fc + row*fr, signed
    localparam int MAG_W   = 37;          // magnitude of the angle
    localparam int EXT_BITS = 24;         // extra fraction bits for the reduction
    localparam int R_W     = MAG_W + EXT_BITS;
    localparam int Z_W     = 34;          // CORDIC x, y, z in Q30 with headroom
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int CORDIC_STAGES = 30;

    // packed stream widths
    localparam int IN_W     = 2 * POS_W + 6 * DATA_W;
    localparam int IN_BUS_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_BUS_W = 4 * DATA_W;

    // angle constants
    localparam logic [63:0]      PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [ACC_W-1:0] RND_Q30   = 65'sd536870912;

    // query and key pair of one request
    typedef struct packed {
        logic signed [DATA_W-1:0] k1;
        logic signed [DATA_W-1:0] k0;
        logic signed [DATA_W-1:0] q1;
        logic signed [DATA_W-1:0] q0;
    } qk_t;

    // arctangent of 2^-i in Q30
    function automatic logic signed [Z_W-1:0] cordic_atan(input int unsigned i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:       a = 34'sd843314857;
            1:       a = 34'sd497837829;
            2:       a = 34'sd263043837;
            3:       a = 34'sd133525159;
            4:       a = 34'sd67021687;
            5:       a = 34'sd33543516;
            6:       a = 34'sd16775851;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194283;
            9:       a = 34'sd2097149;
            10:      a = 34'sd1048576;
            default: a = 34'sd1 <<< (30 - i);
        endcase
        return a;
    endfunction

endpackage

[design/rotary_position_embedding_2d_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_position_embedding_2d_top
// Rotates one query pair and one key pair by a 2D board-position angle.
// ----------------------------------------------------------------------------
//  channel | dir | signals                          | content
//  s_      | in  | s_tvalid s_tready s_tdata[207:0] | position, frequencies, q/k pair
//  m_      | out | m_tvalid m_tready m_tdata[127:0] | rotated q/k pair
//
//  One request per clock while the output is not stalled. Stages: 3 angle
//  stages, 35 - FRAC_BITS restoring steps of the modulo-two-pi reduction,
//  4 wrap/fold stages, 30 CORDIC stages and 4 rotation stages. Frequencies
//  are Q16.16 at the default FRAC_BITS. Synchronous active-low reset
//  clears the valid bits only. A stalled output freezes the pipeline; a
//  one-entry skid register at the input still takes one request during such a stall.
// ----------------------------------------------------------------------------
module rotary_position_embedding_2d_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_col, pos_row, freq_col, freq_row, query_even, query_odd,
    // key_even, key_odd (lowest first), zero filled to 208 bits
    input  logic [rpe2d_pkg::IN_BUS_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // rot_query_even, rot_query_odd, rot_key_even, rot_key_odd (lowest first)
    output logic [rpe2d_pkg::OUT_BUS_W-1:0]  m_tdata
);
    import rpe2d_pkg::*;

    // reduction constants, derived from the fraction width
    localparam int SH    = 59 - (FRAC_BITS + EXT_BITS);
    localparam logic [63:0] TP64 = (PI_Q60 + (64'd1 << (SH - 1))) >> SH;
    localparam logic [R_W-1:0] TP_R = TP64[R_W-1:0];
    localparam int TOQ30 = FRAC_BITS + EXT_BITS - 30;
    localparam logic [R_W-1:0] RND_Z = R_W'(64'd1 << (TOQ30 - 1));
    localparam int NQ    = 35 - FRAC_BITS;       // quotient bits of |angle| / 2pi

    // stage map
    localparam int D0  = 3 + NQ;                 // sign fix
    localparam int C0  = D0 + 4;                 // first CORDIC stage
    localparam int QK_N = C0 + 31;               // stages carrying the q/k pair
    localparam int NST = C0 + 34;

    // input skid register
    logic              skid_valid_reg, skid_valid_next;
    logic [IN_W-1:0]   skid_data_reg;
    logic [IN_W-1:0]   src;
    logic              src_valid, s_acc, adv;

    logic [NST-1:0]    v_reg, v_next;

    logic [POS_W-1:0]        src_col, src_row;
    logic signed [DATA_W-1:0] src_fc, src_fr;
    qk_t                     src_qk;

    // angle stages
    logic signed [ANG_W-1:0] pc_reg, pc_next, pr_reg, pr_next, ang_reg, ang_next;
    // reduction
    logic [R_W-1:0] rdiv_reg [0:NQ];
    logic [R_W-1:0] rdiv_next [0:NQ];
    logic           sgn_reg [0:NQ];
    logic           sgn_next [0:NQ];
    logic [R_W-1:0] rfix_reg, rfix_next;
    logic [R_W-1:0] zsum;
    logic signed [Z_W-1:0] zr_reg, zr_next, zw_reg, zw_next;
    // CORDIC
    logic signed [Z_W-1:0] cx_reg [0:CORDIC_STAGES];
    logic signed [Z_W-1:0] cx_next [0:CORDIC_STAGES];
    logic signed [Z_W-1:0] cy_reg [0:CORDIC_STAGES];
    logic signed [Z_W-1:0] cy_next [0:CORDIC_STAGES];
    logic signed [Z_W-1:0] cz_reg [0:CORDIC_STAGES];
    logic signed [Z_W-1:0] cz_next [0:CORDIC_STAGES];
    logic                  fneg_reg [0:CORDIC_STAGES];
    logic                  fneg_next [0:CORDIC_STAGES];
    // rotation
    logic signed [Z_W-1:0]    cneg, sneg;
    logic signed [DATA_W-1:0] cos_reg, cos_next, sin_reg, sin_next;
    logic signed [PROD_W-1:0] prod_reg [0:7];
    logic signed [PROD_W-1:0] prod_next [0:7];
    logic signed [ACC_W-1:0]  acc_reg [0:3];
    logic signed [ACC_W-1:0]  acc_next [0:3];
    logic [DATA_W-1:0]        out_reg [0:3];
    logic [DATA_W-1:0]        out_next [0:3];
    logic signed [ACC_W-31:0] acc_sh;
    // q/k payload line
    qk_t qk_reg [0:QK_N-1];
    qk_t qk_next [0:QK_N-1];

    // handshake and skid
    assign s_tready  = !skid_valid_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign adv       = !v_reg[NST-1] || m_tready;
    assign src       = skid_valid_reg ? skid_data_reg : s_tdata[IN_W-1:0];
    assign src_valid = skid_valid_reg || s_acc;
    assign skid_valid_next = skid_valid_reg ? !adv : (s_acc && !adv);
    assign v_next    = {v_reg[NST-2:0], src_valid};

    // request fields
    assign src_col = src[4:0];
    assign src_row = src[9:5];
    assign src_fc  = $signed(src[41:10]);
    assign src_fr  = $signed(src[73:42]);
    assign src_qk.q0 = $signed(src[105:74]);
    assign src_qk.q1 = $signed(src[137:106]);
    assign src_qk.k0 = $signed(src[169:138]);
    assign src_qk.k1 = $signed(src[201:170]);

    // angle: products, sum, sign and magnitude
    always_comb begin
        pc_next  = $signed({1'b0, src_col}) * src_fc;
        pr_next  = $signed({1'b0, src_row}) * src_fr;
        ang_next = pc_reg + pr_reg;
        sgn_next[0] = ang_reg[ANG_W-1];
        rdiv_next[0] = ang_reg[ANG_W-1] ? {MAG_W'(-ang_reg), {EXT_BITS{1'b0}}}
                                        : {MAG_W'(ang_reg), {EXT_BITS{1'b0}}};
        // restoring reduction, one quotient bit per stage, top bit first
        for (int k = 0; k < NQ; k++) begin
            sgn_next[k+1] = sgn_reg[k];
            if (rdiv_reg[k] >= (TP_R << (NQ - 1 - k)))
                rdiv_next[k+1] = rdiv_reg[k] - (TP_R << (NQ - 1 - k));
            else
                rdiv_next[k+1] = rdiv_reg[k];
        end
    end

    // non-negative remainder, rounding to Q30, wrap and fold
    always_comb begin
        if (sgn_reg[NQ] && (rdiv_reg[NQ] != '0))
            rfix_next = TP_R - rdiv_reg[NQ];
        else
            rfix_next = rdiv_reg[NQ];
        zsum    = rfix_reg + RND_Z;
        zr_next = $signed(Z_W'(zsum >> TOQ30));
        zw_next = (zr_reg > PI_Q30) ? zr_reg - TWO_PI_Q30 : zr_reg;
        cx_next[0] = GAIN_Q30;
        cy_next[0] = '0;
        if (zw_reg > HALF_PI_Q30) begin
            cz_next[0]   = zw_reg - PI_Q30;
            fneg_next[0] = 1'b1;
        end else if (zw_reg < -HALF_PI_Q30) begin
            cz_next[0]   = zw_reg + PI_Q30;
            fneg_next[0] = 1'b1;
        end else begin
            cz_next[0]   = zw_reg;
            fneg_next[0] = 1'b0;
        end
    end

    // CORDIC rotation stages
    always_comb begin
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            fneg_next[i+1] = fneg_reg[i];
            if (!cz_reg[i][Z_W-1]) begin
                cx_next[i+1] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] + (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] - cordic_atan(i);
            end else begin
                cx_next[i+1] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] - (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] + cordic_atan(i);
            end
        end
    end

    // undo the fold, then rotate both pairs
    always_comb begin
        cneg     = -cx_reg[CORDIC_STAGES];
        sneg     = -cy_reg[CORDIC_STAGES];
        cos_next = fneg_reg[CORDIC_STAGES] ? cneg[DATA_W-1:0]
                                           : cx_reg[CORDIC_STAGES][DATA_W-1:0];
        sin_next = fneg_reg[CORDIC_STAGES] ? sneg[DATA_W-1:0]
                                           : cy_reg[CORDIC_STAGES][DATA_W-1:0];
        prod_next[0] = qk_reg[QK_N-1].q0 * cos_reg;
        prod_next[1] = qk_reg[QK_N-1].q1 * sin_reg;
        prod_next[2] = qk_reg[QK_N-1].q0 * sin_reg;
        prod_next[3] = qk_reg[QK_N-1].q1 * cos_reg;
        prod_next[4] = qk_reg[QK_N-1].k0 * cos_reg;
        prod_next[5] = qk_reg[QK_N-1].k1 * sin_reg;
        prod_next[6] = qk_reg[QK_N-1].k0 * sin_reg;
        prod_next[7] = qk_reg[QK_N-1].k1 * cos_reg;
        acc_next[0] = prod_reg[0] - prod_reg[1] + RND_Q30;
        acc_next[1] = prod_reg[2] + prod_reg[3] + RND_Q30;
        acc_next[2] = prod_reg[4] - prod_reg[5] + RND_Q30;
        acc_next[3] = prod_reg[6] + prod_reg[7] + RND_Q30;
        acc_sh = '0;
        // shift out the Q30 fraction and saturate
        for (int n = 0; n < 4; n++) begin
            acc_sh = acc_reg[n][ACC_W-1:30];
            if (acc_sh > $signed({{(ACC_W-30-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}}))
                out_next[n] = {1'b0, {(DATA_W-1){1'b1}}};
            else if (acc_sh < $signed({{(ACC_W-30-DATA_W){1'b1}}, 1'b1,
                                       {(DATA_W-1){1'b0}}}))
                out_next[n] = {1'b1, {(DATA_W-1){1'b0}}};
            else
                out_next[n] = acc_sh[DATA_W-1:0];
        end
    end

    // payload line
    always_comb begin
        qk_next[0] = src_qk;
        for (int i = 1; i < QK_N; i++)
            qk_next[i] = qk_reg[i-1];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            v_reg          <= '0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            if (adv)
                v_reg <= v_next;
        end
    end

    // data registers
    always_ff @(posedge aclk) begin
        if (s_acc)
            skid_data_reg <= s_tdata[IN_W-1:0];
        if (adv) begin
            pc_reg   <= pc_next;
            pr_reg   <= pr_next;
            ang_reg  <= ang_next;
            rdiv_reg <= rdiv_next;
            sgn_reg  <= sgn_next;
            rfix_reg <= rfix_next;
            zr_reg   <= zr_next;
            zw_reg   <= zw_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            cz_reg   <= cz_next;
            fneg_reg <= fneg_next;
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            out_reg  <= out_next;
            qk_reg   <= qk_next;
        end
    end

    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};

endmodule

[tb/rotary_position_embedding_2d_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_position_embedding_2d_top_test
// Stream-level test of the 2D rotary position embedding block. A driver
// feeds position/frequency/query/key requests from a queue. A built-in
// predictor forms the angle, reduces it modulo two pi, runs the CORDIC and
// rotates both pairs. A monitor checks every rotated result in order against
// the predictions. Both sides idle at random.
// ----------------------------------------------------------------------------
module rotary_position_embedding_2d_top_test;

    localparam int  LATENCY    = 60;      // DUT pipeline depth at Q16.16
    localparam int  IDLE_LIMIT = 2000;    // cycles without any handshake
    localparam int  N_RANDOM   = 1450;

    // angle constants, Q30 unless noted
    localparam logic [63:0] PI_FRAC60   = 64'h3243F6A8885A308D;
    localparam longint      ANG_PI      = 64'sd3373259426;
    localparam longint      ANG_TWO_PI  = 64'sd6746518852;
    localparam longint      ANG_HALF_PI = 64'sd1686629713;
    localparam longint      CORDIC_X0   = 64'sd652032874;
    // arctan(2^-i) for the first eleven CORDIC stages, entry 0 lowest
    localparam logic [10:0][31:0] ATAN_Q30 = {
        32'd1048576, 32'd2097149, 32'd4194283, 32'd8388437, 32'd16775851,
        32'd33543516, 32'd67021687, 32'd133525159, 32'd263043837,
        32'd497837829, 32'd843314857
    };

    typedef struct packed {
        logic [4:0]  pos_col;
        logic [4:0]  pos_row;
        logic [31:0] freq_col;
        logic [31:0] freq_row;
        logic [31:0] query_even;
        logic [31:0] query_odd;
        logic [31:0] key_even;
        logic [31:0] key_odd;
    } pair_req_t;

    typedef struct packed {
        logic      drain;                 // hold off until all results are in
        pair_req_t req;
    } queued_req_t;

    typedef struct packed {
        logic [31:0] rq_even;
        logic [31:0] rq_odd;
        logic [31:0] rk_even;
        logic [31:0] rk_odd;
    } rot_pair_t;

    logic                              aclk;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [rpe2d_pkg::IN_BUS_W-1:0]    s_tdata  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [rpe2d_pkg::OUT_BUS_W-1:0]   m_tdata;

    queued_req_t pending_reqs[$];
    rot_pair_t   expected_rot[$];
    queued_req_t next_item;
    pair_req_t   cur_req;
    int          n_total    = 0;
    int          n_directed = 0;
    int          n_sent     = 0;
    int          n_checked  = 0;
    int          n_errors   = 0;
    int          tx_gap     = 0;
    int          tx_calm    = 0;
    int          rx_stall   = 0;
    int          rx_calm    = 0;
    int          idle_cycles = 0;

    rotary_position_embedding_2d_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // round a Q30 product sum to Q0 and clamp to 32 bits
    function automatic logic [31:0] round_sat(input longint acc);
        longint r;
        r = (acc + 64'sd536870912) >>> 30;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // angle, reduction, fold, CORDIC and rotation of one request
    function automatic rot_pair_t rotate_pair(input pair_req_t r);
        longint    two_pi_ext, angle, resid, z, x, y, dx, dy, step_atan;
        longint    q0, q1, k0, k1;
        logic      flip;
        rot_pair_t o;
        two_pi_ext = longint'((PI_FRAC60 + 64'd262144) >> 19);
        angle = longint'(r.pos_col) * longint'($signed(r.freq_col))
              + longint'(r.pos_row) * longint'($signed(r.freq_row));
        resid = (angle <<< 24) % two_pi_ext;
        if (resid < 0)
            resid = resid + two_pi_ext;
        z = (resid + 64'sd512) >>> 10;
        if (z > ANG_PI)
            z = z - ANG_TWO_PI;
        flip = 1'b0;
        if (z > ANG_HALF_PI) begin
            z = z - ANG_PI;
            flip = 1'b1;
        end else if (z < -ANG_HALF_PI) begin
            z = z + ANG_PI;
            flip = 1'b1;
        end
        x = CORDIC_X0;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            step_atan = (i < 11) ? longint'(ATAN_Q30[i]) : (64'sd1 <<< (30 - i));
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - step_atan;
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + step_atan;
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        q0 = longint'($signed(r.query_even));
        q1 = longint'($signed(r.query_odd));
        k0 = longint'($signed(r.key_even));
        k1 = longint'($signed(r.key_odd));
        o.rq_even = round_sat(q0 * x - q1 * y);
        o.rq_odd  = round_sat(q0 * y + q1 * x);
        o.rk_even = round_sat(k0 * x - k1 * y);
        o.rk_odd  = round_sat(k0 * y + k1 * x);
        return o;
    endfunction

    function automatic logic [rpe2d_pkg::IN_BUS_W-1:0] pack_req(input pair_req_t r);
        return {6'd0, r.key_odd, r.key_even, r.query_odd, r.query_even,
                r.freq_row, r.freq_col, r.pos_row, r.pos_col};
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 88)
            return $urandom_range(1, 3);
        else if (p < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // frequency: mostly a few radians, some full range, some edge values
    function automatic logic [31:0] rand_freq();
        int p, v;
        p = $urandom_range(0, 9);
        if (p < 6) begin
            v = $urandom_range(0, 524288) - 262144;
            return v;
        end else if (p < 9)
            return $urandom;
        else
            return edge_word();
    endfunction

    function automatic logic [31:0] rand_elem();
        int p, v;
        p = $urandom_range(0, 9);
        if (p < 5) begin
            v = $urandom_range(0, 2097152) - 1048576;
            return v;
        end else if (p < 8)
            return $urandom;
        else
            return edge_word();
    endfunction

    function automatic logic [4:0] rand_pos();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 31);
        return $urandom_range(0, 18);
    endfunction

    task automatic add_req(input logic [4:0] col, input logic [4:0] row,
                           input logic [31:0] fc, input logic [31:0] fr,
                           input logic [31:0] q0, input logic [31:0] q1,
                           input logic [31:0] k0, input logic [31:0] k1,
                           input logic drain);
        queued_req_t e;
        e.drain          = drain;
        e.req.pos_col    = col;
        e.req.pos_row    = row;
        e.req.freq_col   = fc;
        e.req.freq_row   = fr;
        e.req.query_even = q0;
        e.req.query_odd  = q1;
        e.req.key_even   = k0;
        e.req.key_odd    = k1;
        pending_reqs.push_back(e);
        n_total++;
    endtask

    task automatic check_word(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
            n_errors++;
        end
    endtask

    // driver: present queued requests, gap between them at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_rot.push_back(rotate_pair(cur_req));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0 &&
                             !(pending_reqs[0].drain && expected_rot.size() != 0)) begin
                    next_item = pending_reqs.pop_front();
                    cur_req   = next_item.req;
                    s_tdata  <= pack_req(cur_req);
                    s_tvalid <= 1'b1;
                    if (tx_calm != 0)
                        tx_calm--;
                    else if ($urandom_range(0, 99) < 3)
                        tx_calm = $urandom_range(40, 150);
                    tx_gap = (tx_calm != 0) ? 0 : idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check results in order, stall the output at random
    always @(posedge aclk) begin : rx_side
        rot_pair_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_rot.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    n_errors++;
                end else begin
                    want = expected_rot.pop_front();
                    check_word("rot_query_even", want.rq_even, m_tdata[31:0]);
                    check_word("rot_query_odd",  want.rq_odd,  m_tdata[63:32]);
                    check_word("rot_key_even",   want.rk_even, m_tdata[95:64]);
                    check_word("rot_key_odd",    want.rk_odd,  m_tdata[127:96]);
                    n_checked++;
                end
            end
            if (rx_calm != 0)
                rx_calm--;
            else if ($urandom_range(0, 499) == 0)
                rx_calm = $urandom_range(100, 400);
            if (rx_stall != 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else if (rx_calm == 0 && $urandom_range(0, 99) < 20) begin
                rx_stall = idle_len();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: give up after a long stretch without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        // directed: zero angle, quadrant edges, wrap, extremes, saturation
        add_req(0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_req(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_req(1, 0, 32'd102944, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65536, 1'b0);
        add_req(1, 0, 32'd102943, 32'd0, 32'd65536, 32'd65536, 32'd1, 32'd1, 1'b0);
        add_req(1, 0, 32'd102945, 32'd0, 32'd65536, 32'd65536, 32'd1, 32'd1, 1'b0);
        add_req(1, 0, 32'd205887, 32'd0, 32'd65536, 32'd65536, -32'sd65536,
                32'd65536, 1'b0);
        add_req(0, 1, 32'd0, -32'sd102944, 32'd65536, 32'd0, 32'd0, 32'd65536, 1'b0);
        add_req(0, 1, 32'd0, -32'sd205887, 32'd65536, 32'd0, 32'd0, 32'd65536, 1'b0);
        add_req(1, 0, 32'd411775, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65536, 1'b0);
        add_req(1, 0, -32'sd411775, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65536, 1'b0);
        add_req(2, 0, 32'd205887, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65536, 1'b0);
        add_req(1, 0, 32'd51472, 32'd0, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_req(1, 0, 32'd51472, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_req(31, 31, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65536, 32'd131072,
                32'hFFFF_0000, 32'd12345, 1'b0);
        add_req(31, 31, 32'h8000_0000, 32'h8000_0000, 32'd65536, 32'd131072,
                32'hFFFF_0000, 32'd12345, 1'b0);
        add_req(31, 0, 32'h8000_0000, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1,
                32'd1, 1'b0);
        add_req(0, 31, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0,
                32'hFFFF_FFFF, 1'b0);
        add_req(18, 18, 32'd65536, -32'sd65536, 32'd300000, -32'sd70000,
                32'd5, -32'sd5, 1'b0);
        add_req(19, 0, 32'd12345, 32'd777, 32'd65536, 32'd65536, 32'd65536,
                32'd65536, 1'b0);
        add_req(25, 30, -32'sd9000, 32'd4000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 1'b0);
        add_req(1, 1, 32'd102944, -32'sd102944, 32'h1234_5678, 32'h8765_4321,
                32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b0);
        add_req(1, 0, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        n_directed = n_total;

        // random part; the first request waits for the directed results
        for (int i = 0; i < N_RANDOM; i++)
            add_req(rand_pos(), rand_pos(), rand_freq(), rand_freq(),
                    rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                    (i == 0) || ($urandom_range(0, 299) == 0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_sent != n_total)
            @(posedge aclk);
        while (expected_rot.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);

        $display("Checked %0d of %0d requests (%0d directed, %0d random); %0d mismatches.",
                 n_checked, n_total, n_directed, n_total - n_directed, n_errors);
        $display("Covered quadrant edges, wrap-around, full-range angles, saturation, stalls.");
        if (n_errors == 0 && n_checked == n_total) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
